// ----- src/fwcp_pkg.sv -----
// Package for the flagged word code packer.
// Holds the queue entry type and the word format constants; no dependencies.
package fwcp_pkg;

  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned CONTENT_BITS = 31;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CONTENT_BITS-1:0] content_t;

  // Words produced by one input beat: full words, then optional flush and trailer.
  typedef struct packed {
    logic [1:0] n_full;
    logic       flush;
    content_t   word0;
    content_t   word1;
    content_t   flush_word;
    logic [5:0] pad;
  } fwcp_entry_t;

endpackage

// ----- src/flagged_word_code_packer.sv -----
// Flagged word code packer, top level.
// Input beats carry one prefix code (bits, length) and a block end mark on tlast.
// Code bits are packed MSB first into 32-bit words whose bit 31 is a 0 flag.
// On the block end beat the open word is zero padded and sent, then a trailer
// word with bit 31 set and the pad count in the low bits (tuser marks it).
// out_tlast marks the last word caused by an input beat; beats that fill no
// word produce nothing.
// The first word of a beat passes through the queue and then the output register.
// Throughput: one beat per cycle while each beat yields at most one word and the
// receiver does not stall; a beat yielding several words (up to four) occupies the
// single output register, which drains one word per cycle while out_tready is high.
// A two-entry queue separates the packing stage from the output serializer, so
// input is taken while a word waits on a stalled receiver; in_tready drops only
// when both queue entries are occupied.
// Reset clears the open word, the queue and the output valid.
// Depends on fwcp_pkg, fwcp_front, fwcp_queue, fwcp_back.
module flagged_word_code_packer #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] code_bits, [37:32] code_length, [39:38] zero
  input  logic        in_tlast,   // block_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] out_word
  output logic        out_tuser,  // is_trailer
  output logic        out_tlast   // last_of_run
);
  import fwcp_pkg::*;

  logic        push;
  logic        has_space;
  logic        pop;
  logic        head_valid;
  fwcp_entry_t push_entry;
  fwcp_entry_t head_entry;

  assign in_tready = has_space;

  fwcp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (has_space),
    .code_bits   (in_tdata[31:0]),
    .code_length (in_tdata[37:32]),
    .block_end   (in_tlast),
    .push        (push),
    .entry       (push_entry)
  );

  fwcp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .has_space  (has_space),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  fwcp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- src/fwcp_front.sv -----
// Front end: holds the open word, packs one code per beat and forms a queue entry.
// Depends on fwcp_pkg.
module fwcp_front #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [31:0]         code_bits,
  input  logic [5:0]          code_length,
  input  logic                block_end,
  output logic                push,
  output fwcp_pkg::fwcp_entry_t entry
);
  import fwcp_pkg::*;

  content_t    pw_r, pw_nxt;
  logic [4:0]  fill_r, fill_nxt;

  logic [5:0]  len;
  logic [4:0]  cnt;
  logic [63:0] code_m;
  logic [63:0] comb;
  logic [63:0] shifted;
  logic [5:0]  total;
  logic [5:0]  rem6;
  logic [4:0]  rem;
  logic [1:0]  nfull;
  content_t    rem_bits;
  logic [4:0]  fill_after;
  logic        fire;

  always_comb begin
    len = code_length;
    if (len > 6'(MAX_CODE_LEN)) begin
      len = 6'(MAX_CODE_LEN);
    end
    if (len > 6'(WORD_BITS)) begin
      len = 6'(WORD_BITS);
    end
    cnt    = (fill_r == 5'd0) ? 5'd0 : fill_r - 5'd1;
    code_m = {32'b0, code_bits} & ~({64{1'b1}} << len);
    comb   = ({33'b0, pw_r} << len) | code_m;
    total  = {1'b0, cnt} + len;
    if (total >= 6'd62) begin
      nfull = 2'd2;
      rem6  = total - 6'd62;
    end else if (total >= 6'd31) begin
      nfull = 2'd1;
      rem6  = total - 6'd31;
    end else begin
      nfull = 2'd0;
      rem6  = total;
    end
    rem      = rem6[4:0];
    shifted  = comb >> (total - 6'd31);
    rem_bits = comb[CONTENT_BITS-1:0] & ~({CONTENT_BITS{1'b1}} << rem);
    fill_after = (nfull != 2'd0 && rem == 5'd0) ? 5'd0 : rem + 5'd1;

    entry.n_full     = nfull;
    entry.flush      = block_end;
    entry.word0      = shifted[CONTENT_BITS-1:0];
    entry.word1      = comb[CONTENT_BITS-1:0];
    entry.flush_word = (fill_after == 5'd0) ? '0 : rem_bits << (5'd31 - rem);
    entry.pad        = 6'd32 - {1'b0, fill_after};

    fire = in_valid && in_ready;
    push = fire && (nfull != 2'd0 || block_end);

    pw_nxt   = pw_r;
    fill_nxt = fill_r;
    if (fire) begin
      pw_nxt   = block_end ? '0 : rem_bits;
      fill_nxt = block_end ? 5'd0 : fill_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r   <= '0;
      fill_r <= '0;
    end else begin
      pw_r   <= pw_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

// ----- src/fwcp_queue.sv -----
// Two-entry queue between the packing front end and the word serializer.
// Depends on fwcp_pkg.
module fwcp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fwcp_pkg::fwcp_entry_t push_entry,
  output logic                  has_space,
  input  logic                  pop,
  output logic                  head_valid,
  output fwcp_pkg::fwcp_entry_t head_entry
);
  import fwcp_pkg::*;

  fwcp_entry_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign has_space  = count_r != QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- src/fwcp_back.sv -----
// Back end: walks the head queue entry word by word into the output register.
// Depends on fwcp_pkg.
module fwcp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  fwcp_pkg::fwcp_entry_t head_entry,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);
  import fwcp_pkg::*;

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [31:0] data_r, data_nxt;
  logic        user_r, user_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  n_words;
  logic        load;
  logic        is_last;

  always_comb begin
    n_words = {1'b0, head_entry.n_full} + (head_entry.flush ? 3'd2 : 3'd0);
    is_last = {1'b0, idx_r} == n_words - 3'd1;
    load    = head_valid && (!valid_r || out_tready);
    pop     = load && is_last;

    valid_nxt = valid_r && !out_tready;
    data_nxt  = data_r;
    user_nxt  = user_r;
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      last_nxt  = is_last;
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
      if (idx_r < head_entry.n_full) begin
        data_nxt = {1'b0, (idx_r == 2'd0) ? head_entry.word0 : head_entry.word1};
        user_nxt = 1'b0;
      end else if (idx_r == head_entry.n_full) begin
        data_nxt = {1'b0, head_entry.flush_word};
        user_nxt = 1'b0;
      end else begin
        data_nxt = {1'b1, 25'b0, head_entry.pad};
        user_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule
